>>> hdl/ssam_pkg.sv
package ssam_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_FETCH   = 2'd1,
    OP_REPLACE = 2'd2,
    OP_ERASE   = 2'd3
  } op_t;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SEARCH  = 7'b0000010,
    S_COMPARE = 7'b0000100,
    S_DECIDE  = 7'b0001000,
    S_INSERT  = 7'b0010000,
    S_REMOVE  = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_t;

endpackage

>>> hdl/sorted_sparse_array_map.sv
// Each search probe issues a RAM read in S_SEARCH and compares the key in S_COMPARE, with up
// to clog2(CAPACITY+1) probes before S_DECIDE. An insert or erase then shifts the later
// entries through S_INSERT or S_REMOVE, and every operation ends in S_FINISH.
// One item is processed at a time; the single write port of the key and value RAMs
// sets the shift rate. The result register frees the input side while a result waits.
// Reset (synchronous, active high) clears the control state and the entry count only.
module sorted_sparse_array_map
  import ssam_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32,
  parameter int KEY_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] result_value,
  output logic        found,
  output logic        status,
  output logic [6:0]  entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t                state;
  op_t                   op_r;
  logic [KEY_BITS-1:0]   k_r;
  logic [VALUE_BITS-1:0] v_r;
  logic [VALUE_BITS-1:0] res;
  logic [CW-1:0]         lo;
  logic [CW-1:0]         hi;
  logic [CW-1:0]         pos;
  logic [CW-1:0]         ptr;
  logic [CW-1:0]         count;
  logic [AW-1:0]         wa;
  logic                  pend;
  logic                  hit;
  logic                  stat;

  logic [CW-1:0]              mid;
  logic [CW-1:0]              ptr_dec;
  logic                       full;
  logic                       accept;
  logic                       rsp_free;
  logic [KEY_BITS+31:0]       key_ext;
  logic [VALUE_BITS+31:0]     val_ext;
  logic [VALUE_BITS+31:0]     res_ext;
  logic [CW+6:0]              cnt_ext;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic [KEY_BITS-1:0]   wkey;
  logic [VALUE_BITS-1:0] wval;
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;

  assign mid     = lo + ((hi - lo) >> 1);
  assign ptr_dec = ptr - CW'(1);
  assign full    = (count >= CW'(CAPACITY));
  assign key_ext = {{KEY_BITS{1'b0}}, key};
  assign val_ext = {{VALUE_BITS{1'b0}}, value};
  assign res_ext = {32'b0, res};
  assign cnt_ext = {7'b0, count};

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  ssam_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wkey),
    .raddr (raddr),
    .rdata (key_rd)
  );

  ssam_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wval),
    .raddr (raddr),
    .rdata (val_rd)
  );

  always_comb begin
    we    = 1'b0;
    waddr = pos[AW-1:0];
    wkey  = k_r;
    wval  = v_r;
    raddr = '0;
    unique case (state)
      S_SEARCH: begin
        raddr = mid[AW-1:0];
      end
      S_DECIDE: begin
        if (op_r == OP_REPLACE && hit) begin
          we = 1'b1;
        end
      end
      S_INSERT: begin
        if (pend) begin
          we    = 1'b1;
          waddr = wa;
          wkey  = key_rd;
          wval  = val_rd;
        end else if (ptr <= pos) begin
          we = 1'b1;
        end
        if (ptr > pos) begin
          raddr = ptr_dec[AW-1:0];
        end
      end
      S_REMOVE: begin
        if (pend) begin
          we    = 1'b1;
          waddr = wa;
          wkey  = key_rd;
          wval  = val_rd;
        end
        if (ptr < count) begin
          raddr = ptr[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_r  <= op_t'(req_type);
            k_r   <= key_ext[KEY_BITS-1:0];
            v_r   <= val_ext[VALUE_BITS-1:0];
            lo    <= '0;
            hi    <= count;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (lo < hi) begin
            state <= S_COMPARE;
          end else begin
            hit   <= 1'b0;
            pos   <= lo;
            state <= S_DECIDE;
          end
        end
        S_COMPARE: begin
          if (key_rd == k_r) begin
            hit   <= 1'b1;
            pos   <= mid;
            res   <= val_rd;
            state <= S_DECIDE;
          end else begin
            if (key_rd < k_r) begin
              lo <= mid + CW'(1);
            end else begin
              hi <= mid;
            end
            state <= S_SEARCH;
          end
        end
        S_DECIDE: begin
          stat <= 1'b0;
          pend <= 1'b0;
          unique case (op_r)
            OP_LOOKUP: begin
              if (!hit) begin
                res <= v_r;
              end
              state <= S_FINISH;
            end
            OP_FETCH, OP_REPLACE: begin
              if (!hit || op_r == OP_REPLACE) begin
                res <= v_r;
              end
              if (hit) begin
                state <= S_FINISH;
              end else if (full) begin
                stat  <= 1'b1;
                state <= S_FINISH;
              end else begin
                ptr   <= count;
                state <= S_INSERT;
              end
            end
            OP_ERASE: begin
              res <= '0;
              if (hit) begin
                ptr   <= pos + CW'(1);
                state <= S_REMOVE;
              end else begin
                state <= S_FINISH;
              end
            end
          endcase
        end
        S_INSERT: begin
          if (ptr > pos) begin
            wa   <= ptr[AW-1:0];
            pend <= 1'b1;
            ptr  <= ptr_dec;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count <= count + CW'(1);
              state <= S_FINISH;
            end
          end
        end
        S_REMOVE: begin
          if (ptr < count) begin
            wa   <= ptr_dec[AW-1:0];
            pend <= 1'b1;
            ptr  <= ptr + CW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count <= count - CW'(1);
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (rsp_free) begin
            result_value <= res_ext[31:0];
            found        <= hit;
            status       <= stat;
            entry_count  <= cnt_ext[6:0];
            state        <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count)) || (count == $past(count) + CW'(1))
             || (count + CW'(1) == $past(count)))
    else $error("Entry count changed by more than one.");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT) |-> !full)
    else $error("Insert started on a full store.");

  a_status_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(status && found))
    else $error("Refused insert reported for a present key.");

endmodule

>>> hdl/ssam_ram.sv
module ssam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
